### sv/sfr_pkg.sv
// Shared types and constants for the stream find-and-replace block.
package sfr_pkg;

  localparam int PAT_MAX    = 8;
  localparam int REP_MAX    = 8;
  localparam int OUT_CAP    = 4096;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 13;
  localparam int JOB_MAX    = 8;
  localparam int SEL_W      = 3;
  localparam int CHARS_W    = JOB_MAX * CHAR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = 2;
  localparam int JOBQ_CNT_W = 3;

  typedef logic [CHAR_W-1:0]     char_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [SEL_W-1:0]      sel_t;
  typedef logic [JOBQ_PTR_W-1:0] qptr_t;
  typedef logic [JOBQ_CNT_W-1:0] qcnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES = 2'd0,
    REG_PATTERN_LEN   = 2'd1,
    REG_REPLACE_BYTES = 2'd2,
    REG_REPLACE_LEN   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              char_valid;
    logic              run_last;
    logic              stream_end;
    logic              capped_flag;
  } result_t;

  // One input item's worth of results, built by the front end
  typedef struct packed {
    logic [CHARS_W-1:0] chars;
    logic [LEN_W-1:0]   num;
    logic               char_valid;
    logic               stream_end;
    logic               capped;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } jobq_stat_t;

endpackage

### sv/stream_find_replace_top.sv
// Top level of the stream find-and-replace block.
// Replaces every non-overlapping occurrence of the configured pattern (up to 8 characters)
// in the incoming character stream with the configured replacement (up to 8 characters),
// greedily from left to right, flushing held characters on the item marked last. One input
// item is accepted per cycle whenever the 4-entry job queue has room; each item is matched
// and classified in the cycle it is accepted. The result side delivers one result per cycle
// while results are popped, so an item yielding k results (1 to 8) holds the back end until
// all k are out, and the sustained input rate is set by the number of results per item. Items
// that yield no result cost the back end nothing. With a nonzero pattern length, output beyond
// 4096 characters per stream is dropped and the sticky capped flag is raised until reset. Write
// configuration only while the block is idle; writing the pattern length restarts the stream.
module stream_find_replace_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  sfr_pkg::item_t                 item,
  output logic                           empty,
  input  logic                           pop,
  output sfr_pkg::result_t               result,
  input  logic                           cfg_wr_en,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                accept;
  logic                job_push;
  logic                job_pop;
  sfr_pkg::job_t       job_in;
  sfr_pkg::job_t       job_head;
  sfr_pkg::jobq_stat_t jq_stat;

  assign full   = jq_stat.full;
  assign accept = push && !jq_stat.full;

  sfr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .accept    (accept),
    .job_push  (job_push),
    .job       (job_in)
  );

  sfr_jobq u_jobq (
    .clk  (clk),
    .rst  (rst),
    .push (job_push),
    .din  (job_in),
    .pop  (job_pop),
    .dout (job_head),
    .stat (jq_stat)
  );

  sfr_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (job_head),
    .stat   (jq_stat),
    .q_pop  (job_pop),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  // A job is only built when the queue has room for it
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !jq_stat.full)
    else $error("job pushed into a full queue");

  // Every queued job carries between one and eight results
  a_job_num: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (job_in.num != '0 &&
                  job_in.num <= sfr_pkg::len_t'(sfr_pkg::JOB_MAX)))
    else $error("job result count out of range");

  // An end marker is a single result that closes the stream
  a_marker: assert property (@(posedge clk) disable iff (rst)
    (job_push && !job_in.char_valid) |->
      (job_in.num == sfr_pkg::len_t'(1) && job_in.stream_end))
    else $error("malformed end marker job");

  // The end of the stream is always the last result of its item
  a_end_run: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (!result.stream_end || result.run_last))
    else $error("stream end without run last");

endmodule

### sv/sfr_front.sv
// Front end: window, pattern match, capacity accounting and job building.
module sfr_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  sfr_pkg::item_t                   item,
  input  logic                             accept,
  output logic                             job_push,
  output sfr_pkg::job_t                    job
);

  logic [sfr_pkg::CHARS_W-1:0] pattern_bytes;
  sfr_pkg::len_t               pattern_len;
  logic [sfr_pkg::CHARS_W-1:0] replace_bytes;
  sfr_pkg::len_t               replace_len;

  sfr_pkg::char_t win [sfr_pkg::PAT_MAX];
  sfr_pkg::len_t  wcount;
  sfr_pkg::cnt_t  emitted;
  logic           stopped;
  logic           capped;

  sfr_pkg::char_t              win_ins   [sfr_pkg::PAT_MAX];
  sfr_pkg::char_t              win_shift [sfr_pkg::PAT_MAX];
  logic [sfr_pkg::CHARS_W-1:0] win_flat;
  logic [sfr_pkg::PAT_MAX-1:0] pat_eq;
  sfr_pkg::len_t               m;
  sfr_pkg::len_t               rl;
  sfr_pkg::len_t               cnt_ins;
  sfr_pkg::len_t               cnt_next;
  sfr_pkg::len_t               want;
  sfr_pkg::len_t               num;
  sfr_pkg::cnt_t               avail;
  logic                        win_full;
  logic                        match;
  logic                        use_rep;
  logic                        count_en;
  logic                        shift;
  logic                        cap_hit;
  logic                        marker;

  // Insert the new character, compare against the pattern, shift view
  always_comb begin
    m  = (pattern_len > sfr_pkg::len_t'(sfr_pkg::PAT_MAX)) ?
         sfr_pkg::len_t'(sfr_pkg::PAT_MAX) : pattern_len;
    rl = (replace_len > sfr_pkg::len_t'(sfr_pkg::REP_MAX)) ?
         sfr_pkg::len_t'(sfr_pkg::REP_MAX) : replace_len;
    for (int t = 0; t < sfr_pkg::PAT_MAX; t++) begin
      win_ins[t] = (sfr_pkg::len_t'(t) == wcount) ? item.in_char : win[t];
      win_flat[t*sfr_pkg::CHAR_W +: sfr_pkg::CHAR_W] = win_ins[t];
      pat_eq[t] = (win_ins[t] == pattern_bytes[t*sfr_pkg::CHAR_W +: sfr_pkg::CHAR_W]) ||
                  (sfr_pkg::len_t'(t) >= m);
    end
    for (int t = 0; t < sfr_pkg::PAT_MAX; t++) begin
      if (t < sfr_pkg::PAT_MAX - 1) begin
        win_shift[t] = win_ins[t+1];
      end else begin
        win_shift[t] = '0;
      end
    end
    cnt_ins  = wcount + sfr_pkg::len_t'(1);
    win_full = (m != '0) && (cnt_ins >= m);
    match    = &pat_eq;
    avail    = sfr_pkg::cnt_t'(sfr_pkg::OUT_CAP) - emitted;
  end

  // Decide what this transaction emits and how the state moves
  always_comb begin
    use_rep  = 1'b0;
    count_en = 1'b0;
    shift    = 1'b0;
    cap_hit  = 1'b0;
    want     = '0;
    num      = '0;
    cnt_next = wcount;
    if (m == '0) begin
      num = stopped ? '0 : sfr_pkg::len_t'(1);
    end else if (!stopped) begin
      count_en = 1'b1;
      if (win_full && match) begin
        use_rep  = 1'b1;
        cnt_next = '0;
        if (sfr_pkg::cnt_t'(rl) > avail) begin
          cap_hit = 1'b1;
        end else begin
          num = rl;
        end
      end else begin
        if (win_full) begin
          shift    = 1'b1;
          cnt_next = cnt_ins - sfr_pkg::len_t'(1);
          want     = item.in_last ? cnt_ins : sfr_pkg::len_t'(1);
        end else begin
          cnt_next = cnt_ins;
          want     = item.in_last ? cnt_ins : '0;
        end
        if (sfr_pkg::cnt_t'(want) > avail) begin
          cap_hit = 1'b1;
          num     = avail[sfr_pkg::LEN_W-1:0];
        end else begin
          num = want;
        end
      end
    end
  end

  // Build the job; a last item with nothing to say becomes an end marker
  always_comb begin
    marker         = item.in_last && (num == '0);
    job.chars      = marker ? '0 : (use_rep ? replace_bytes : win_flat);
    job.num        = marker ? sfr_pkg::len_t'(1) : num;
    job.char_valid = !marker;
    job.stream_end = item.in_last;
    job.capped     = capped | cap_hit;
    job_push       = accept && ((num != '0) || item.in_last);
  end

  // Config registers and stream control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes <= '0;
      pattern_len   <= '0;
      replace_bytes <= '0;
      replace_len   <= '0;
      wcount        <= '0;
      emitted       <= '0;
      stopped       <= 1'b0;
      capped        <= 1'b0;
    end else if (cfg_wr_en) begin
      case (sfr_pkg::cfg_reg_t'(cfg_index))
        sfr_pkg::REG_PATTERN_BYTES: begin
          pattern_bytes <= cfg_data[sfr_pkg::CHARS_W-1:0];
        end
        sfr_pkg::REG_PATTERN_LEN: begin
          pattern_len <= cfg_data[sfr_pkg::LEN_W-1:0];
          wcount      <= '0;
          emitted     <= '0;
          stopped     <= 1'b0;
        end
        sfr_pkg::REG_REPLACE_BYTES: begin
          replace_bytes <= cfg_data[sfr_pkg::CHARS_W-1:0];
        end
        sfr_pkg::REG_REPLACE_LEN: begin
          replace_len <= cfg_data[sfr_pkg::LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      capped <= capped | cap_hit;
      if (item.in_last) begin
        wcount  <= '0;
        emitted <= '0;
        stopped <= 1'b0;
      end else begin
        wcount  <= cnt_next;
        stopped <= stopped | cap_hit;
        if (count_en) begin
          emitted <= emitted + sfr_pkg::cnt_t'(num);
        end
      end
    end
  end

  // Window contents; only the first wcount entries are ever read
  always_ff @(posedge clk) begin
    if (accept && count_en) begin
      for (int t = 0; t < sfr_pkg::PAT_MAX; t++) begin
        win[t] <= shift ? win_shift[t] : win_ins[t];
      end
    end
  end

endmodule

### sv/sfr_jobq.sv
// Short job queue between the front end and the result sequencer.
module sfr_jobq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sfr_pkg::job_t       din,
  input  logic                pop,
  output sfr_pkg::job_t       dout,
  output sfr_pkg::jobq_stat_t stat
);

  sfr_pkg::job_t  slots [sfr_pkg::JOBQ_DEPTH];
  sfr_pkg::qptr_t wr_ptr;
  sfr_pkg::qptr_t rd_ptr;
  sfr_pkg::qcnt_t count;

  assign dout       = slots[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == sfr_pkg::qcnt_t'(sfr_pkg::JOBQ_DEPTH));

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sfr_pkg::qptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sfr_pkg::qptr_t'(1);
      end
      if (push && !pop) begin
        count <= count + sfr_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        count <= count - sfr_pkg::qcnt_t'(1);
      end
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

endmodule

### sv/sfr_back.sv
// Back end: walks each job into the output register one character per cycle while it is free or popped.
module sfr_back (
  input  logic                clk,
  input  logic                rst,
  input  sfr_pkg::job_t       head,
  input  sfr_pkg::jobq_stat_t stat,
  output logic                q_pop,
  output sfr_pkg::result_t    result,
  output logic                empty,
  input  logic                pop
);

  sfr_pkg::sel_t    idx;
  logic             out_valid;
  logic             take;
  logic             load;
  logic             last_of_job;
  sfr_pkg::result_t result_next;

  // Pick the current character of the head job
  always_comb begin
    take        = pop && out_valid;
    load        = !stat.empty && (!out_valid || take);
    last_of_job = (sfr_pkg::len_t'(idx) == (head.num - sfr_pkg::len_t'(1)));
    q_pop       = load && last_of_job;
    result_next.out_char    = head.chars[sfr_pkg::CHAR_W*idx +: sfr_pkg::CHAR_W];
    result_next.char_valid  = head.char_valid;
    result_next.run_last    = last_of_job;
    result_next.stream_end  = head.stream_end && last_of_job;
    result_next.capped_flag = head.capped;
  end

  assign empty = !out_valid;

  // Track the output register and the position inside the job
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last_of_job ? '0 : idx + sfr_pkg::sel_t'(1);
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until it is popped
  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule
